// ----- rtl/core/los_pkg.sv -----
// ----------------------------------------------------------------------------
// los_pkg: shared types and constants for lidar obstacle steering
// Field widths, register indexes, sector decode and sweep state record.
// ----------------------------------------------------------------------------
package los_pkg;

  localparam int RANGE_BITS_DEF = 16;
  localparam int ANGLE_W        = 9;
  localparam int CFG_W          = 16;
  localparam int RATE_W         = 10;
  localparam int CMD_W          = 11;
  localparam int SUM_W          = 18;
  localparam int RANK_W         = 10;
  localparam int IDX_W          = 4;

  localparam logic [SUM_W-1:0]   SUM_MAX      = '1;
  localparam logic [CFG_W-1:0]   MIN_FRONT_MM = 16'd15;

  // steering bands on the best angle
  localparam logic [ANGLE_W-1:0] FAST_NEG_LO  = 9'd200;
  localparam logic [ANGLE_W-1:0] FAST_NEG_HI  = 9'd290;
  localparam logic [ANGLE_W-1:0] SLOW_NEG_HI  = 9'd340;
  localparam logic [ANGLE_W-1:0] FAST_POS_LO  = 9'd70;
  localparam logic [ANGLE_W-1:0] FAST_POS_HI  = 9'd160;
  localparam logic [ANGLE_W-1:0] SLOW_POS_LO  = 9'd20;

  // search order starts at the left rear edge of the window and wraps at 360
  localparam logic [ANGLE_W-1:0] SEARCH_BASE  = 9'd260;
  localparam logic [RANK_W-1:0]  RANK_WRAP    = 10'd100;

  // register reset values
  localparam logic [CFG_W-1:0]  RST_RANGE_FLOOR   = 16'd100;
  localparam logic [CFG_W-1:0]  RST_RANGE_CEILING = 16'd12000;
  localparam logic [CFG_W-1:0]  RST_COLL_THRESH   = 16'd450;
  localparam logic [RATE_W-1:0] RST_AVOID_RATE    = 10'd424;
  localparam logic [RATE_W-1:0] RST_FAST_RATE     = 10'd212;
  localparam logic [RATE_W-1:0] RST_SLOW_RATE     = 10'd106;
  localparam logic [RATE_W-1:0] RST_CRUISE_SPEED  = 10'd260;
  localparam logic [RATE_W-1:0] RST_CREEP_SPEED   = 10'd50;

  typedef enum logic [IDX_W-1:0] {
    REG_RANGE_FLOOR     = 4'd0,
    REG_RANGE_CEILING   = 4'd1,
    REG_COLL_THRESHOLD  = 4'd2,
    REG_AVOID_TURN_RATE = 4'd3,
    REG_FAST_TURN_RATE  = 4'd4,
    REG_SLOW_TURN_RATE  = 4'd5,
    REG_CRUISE_SPEED    = 4'd6,
    REG_CREEP_SPEED     = 4'd7
  } cfg_reg_t;

  typedef struct packed {
    logic [CFG_W-1:0]  range_floor;
    logic [CFG_W-1:0]  range_ceiling;
    logic [CFG_W-1:0]  collision_threshold;
    logic [RATE_W-1:0] avoid_turn_rate;
    logic [RATE_W-1:0] fast_turn_rate;
    logic [RATE_W-1:0] slow_turn_rate;
    logic [RATE_W-1:0] cruise_speed;
    logic [RATE_W-1:0] creep_speed;
  } cfg_t;

  typedef struct packed {
    logic front;
    logic left;
    logic right;
    logic search;
  } sector_t;

  typedef struct packed {
    logic               collision;
    logic [SUM_W-1:0]   left_sum;
    logic [SUM_W-1:0]   right_sum;
    logic [CFG_W-1:0]   best_range;
    logic [ANGLE_W-1:0] best_angle;
    logic               best_found;
  } sweep_t;

  // only whole tens inside the scan window belong to any sector
  function automatic sector_t sector_of(input logic [ANGLE_W-1:0] a);
    sector_t s;
    s = '0;
    unique case (a)
      9'd0, 9'd10, 9'd20, 9'd30, 9'd40:   s = '{front: 1'b1, left: 1'b0,
                                              right: 1'b0, search: 1'b1};
      9'd50:                              s = '{front: 1'b0, left: 1'b0,
                                              right: 1'b0, search: 1'b1};
      9'd60, 9'd70, 9'd80, 9'd90:         s = '{front: 1'b0, left: 1'b0,
                                              right: 1'b1, search: 1'b1};
      9'd100, 9'd260, 9'd310:             s = '{front: 1'b0, left: 1'b0,
                                              right: 1'b0, search: 1'b1};
      9'd270, 9'd280, 9'd290, 9'd300:     s = '{front: 1'b0, left: 1'b1,
                                              right: 1'b0, search: 1'b1};
      9'd320, 9'd330, 9'd340, 9'd350:     s = '{front: 1'b1, left: 1'b0,
                                              right: 1'b0, search: 1'b1};
      default:                            s = '0;
    endcase
    return s;
  endfunction

  function automatic logic [RANK_W-1:0] rank_of(input logic [ANGLE_W-1:0] a);
    logic [RANK_W-1:0] ax;
    ax = RANK_W'(a);
    return (a >= SEARCH_BASE) ? (ax - RANK_W'(SEARCH_BASE)) : (ax + RANK_WRAP);
  endfunction

endpackage

// ----- rtl/core/los_if.sv -----
// ----------------------------------------------------------------------------
// los channel interfaces
// Valid/ready channels for samples, steering commands and register writes.
// ----------------------------------------------------------------------------
interface los_in_if #(
  parameter int RANGE_BITS = los_pkg::RANGE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic [los_pkg::ANGLE_W-1:0]   angle;
  logic [RANGE_BITS-1:0]         range_mm;
  logic                          sweep_end;

  modport source (output valid, angle, range_mm, sweep_end, input ready);
  modport sink   (input valid, angle, range_mm, sweep_end, output ready);
endinterface

interface los_out_if;
  logic                              valid;
  logic                              ready;
  logic [los_pkg::RATE_W-1:0]        linear_speed;
  logic signed [los_pkg::CMD_W-1:0]  angular_rate;
  logic                              avoiding;

  modport source (output valid, linear_speed, angular_rate, avoiding, input ready);
  modport sink   (input valid, linear_speed, angular_rate, avoiding, output ready);
endinterface

interface los_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [los_pkg::IDX_W-1:0]    index;
  logic [los_pkg::CFG_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/core/lidar_obstacle_steering.sv -----
// ----------------------------------------------------------------------------
// lidar_obstacle_steering: steering commands from lidar sweeps
// Accumulates one sweep of range samples and issues one speed command per sweep.
// ----------------------------------------------------------------------------
// usage
//   in_ch   : one range sample per beat (angle, range_mm, sweep_end)
//   out_ch  : one command beat per sweep, issued for the beat with sweep_end set
//   cfg_ch  : register writes (index, data), always ready, one per cycle;
//             write only while no sample is in flight
// timing
//   a sample is taken into an input register, then folded into the sweep
//   state in the next cycle; a sweep end loads the command register then, so
//   the command is valid one edge after its sample beat is accepted
//   throughput is one sample per cycle, set by the single compare/add pass
//   between the input register and the sweep/command registers
// stall
//   a stalled command holds; plain samples keep flowing, and only a second
//   sweep end waits in the input register until the command register frees,
//   which drops in_ch.ready
// reset
//   registers return to their defaults, the sweep state clears and the
//   direction lock is released
// ----------------------------------------------------------------------------
module lidar_obstacle_steering #(
  parameter int RANGE_BITS = los_pkg::RANGE_BITS_DEF
) (
  input  logic   clk,
  input  logic   rst_n,
  los_in_if.sink    in_ch,
  los_out_if.source out_ch,
  los_cfg_if.sink   cfg_ch
);
  import los_pkg::*;

  // configuration registers
  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        REG_RANGE_FLOOR:     cfg_nxt.range_floor         = cfg_ch.data;
        REG_RANGE_CEILING:   cfg_nxt.range_ceiling       = cfg_ch.data;
        REG_COLL_THRESHOLD:  cfg_nxt.collision_threshold = cfg_ch.data;
        REG_AVOID_TURN_RATE: cfg_nxt.avoid_turn_rate     = cfg_ch.data[RATE_W-1:0];
        REG_FAST_TURN_RATE:  cfg_nxt.fast_turn_rate      = cfg_ch.data[RATE_W-1:0];
        REG_SLOW_TURN_RATE:  cfg_nxt.slow_turn_rate      = cfg_ch.data[RATE_W-1:0];
        REG_CRUISE_SPEED:    cfg_nxt.cruise_speed        = cfg_ch.data[RATE_W-1:0];
        REG_CREEP_SPEED:     cfg_nxt.creep_speed         = cfg_ch.data[RATE_W-1:0];
        default: ;  // writes outside the map are dropped
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{range_floor:         RST_RANGE_FLOOR,
                 range_ceiling:       RST_RANGE_CEILING,
                 collision_threshold: RST_COLL_THRESH,
                 avoid_turn_rate:     RST_AVOID_RATE,
                 fast_turn_rate:      RST_FAST_RATE,
                 slow_turn_rate:      RST_SLOW_RATE,
                 cruise_speed:        RST_CRUISE_SPEED,
                 creep_speed:         RST_CREEP_SPEED};
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg_ch.ready = 1'b1;

  // input register
  logic                  in_v_r;
  logic [ANGLE_W-1:0]    in_angle_r;
  logic [RANGE_BITS-1:0] in_range_r;
  logic                  in_last_r;
  logic                  adv;
  logic                  take;

  // a sweep end may only leave when the command slot is free or emptying
  assign adv  = in_v_r && (!in_last_r || !out_ch.valid || out_ch.ready);
  assign take = in_ch.valid && in_ch.ready;
  assign in_ch.ready = !in_v_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_v_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      in_angle_r <= in_ch.angle;
      in_range_r <= in_ch.range_mm;
      in_last_r  <= in_ch.sweep_end;
    end
  end

  // sweep accumulation
  sweep_t sw_cur;
  sweep_t sw_upd;

  los_sweep #(
    .RANGE_BITS (RANGE_BITS)
  ) u_sweep (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (adv),
    .angle     (in_angle_r),
    .range_mm  (in_range_r),
    .sweep_end (in_last_r),
    .cfg       (cfg_r),
    .cur       (sw_cur),
    .upd       (sw_upd)
  );

  // command decision on the sweep including the current sample
  logic                     lock_r, lock_nxt;
  logic                     neg_r, neg_nxt;
  logic [RATE_W-1:0]        speed_c;
  logic signed [CMD_W-1:0]  rate_c;
  logic                     avoid_c;
  logic [ANGLE_W-1:0]       aim;
  logic                     issue;

  assign issue = adv && in_last_r;
  assign aim   = sw_upd.best_found ? sw_upd.best_angle : '0;

  always_comb begin
    lock_nxt = lock_r;
    neg_nxt  = neg_r;
    speed_c  = cfg_r.cruise_speed;
    rate_c   = '0;
    avoid_c  = 1'b0;
    if (sw_upd.collision) begin
      // the turn sign sticks until a clear sweep
      lock_nxt = 1'b1;
      neg_nxt  = lock_r ? neg_r : !(sw_upd.right_sum > sw_upd.left_sum);
      speed_c  = cfg_r.creep_speed;
      avoid_c  = 1'b1;
      rate_c   = neg_nxt ? -$signed({1'b0, cfg_r.avoid_turn_rate})
                         :  $signed({1'b0, cfg_r.avoid_turn_rate});
    end else begin
      lock_nxt = 1'b0;
      priority if (aim >= FAST_NEG_LO && aim <= FAST_NEG_HI) begin
        rate_c = -$signed({1'b0, cfg_r.fast_turn_rate});
      end else if (aim >= FAST_NEG_HI && aim <= SLOW_NEG_HI) begin
        rate_c = -$signed({1'b0, cfg_r.slow_turn_rate});
      end else if (aim >= FAST_POS_LO && aim <= FAST_POS_HI) begin
        rate_c = $signed({1'b0, cfg_r.fast_turn_rate});
      end else if (aim >= SLOW_POS_LO && aim <= FAST_POS_LO) begin
        rate_c = $signed({1'b0, cfg_r.slow_turn_rate});
      end else begin
        rate_c = '0;  // straight ahead, also when nothing valid was seen
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lock_r <= 1'b0;
      neg_r  <= 1'b0;
    end else if (issue) begin
      lock_r <= lock_nxt;
      neg_r  <= neg_nxt;
    end
  end

  // command register
  logic                    out_v_r;
  logic [RATE_W-1:0]       out_speed_r;
  logic signed [CMD_W-1:0] out_rate_r;
  logic                    out_avoid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (issue) begin
      out_v_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      out_speed_r <= speed_c;
      out_rate_r  <= rate_c;
      out_avoid_r <= avoid_c;
    end
  end

  assign out_ch.valid        = out_v_r;
  assign out_ch.linear_speed = out_speed_r;
  assign out_ch.angular_rate = out_rate_r;
  assign out_ch.avoiding     = out_avoid_r;

`ifndef SYNTHESIS
  // a new command only appears right after a sweep end left the input register
  a_cmd_from_sweep_end: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_v_r) |-> $past(issue))
    else $error("command appeared without a sweep end");

  // a pending command agrees with the direction lock it produced
  a_lock_matches_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> (out_avoid_r == lock_r))
    else $error("direction lock out of step with pending command");

  // the sweep state starts over after each sweep end
  a_sweep_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    issue |=> (sw_cur == '0))
    else $error("sweep state not cleared after sweep end");
`endif

endmodule

// ----- rtl/core/los_sweep.sv -----
// ----------------------------------------------------------------------------
// los_sweep: per-sweep accumulator
// Collision flag, saturating side sums and farthest reading over one sweep.
// ----------------------------------------------------------------------------
module los_sweep #(
  parameter int RANGE_BITS = los_pkg::RANGE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          step,
  input  logic [los_pkg::ANGLE_W-1:0]   angle,
  input  logic [RANGE_BITS-1:0]         range_mm,
  input  logic                          sweep_end,
  input  los_pkg::cfg_t                 cfg,
  output los_pkg::sweep_t               cur,
  output los_pkg::sweep_t               upd
);
  import los_pkg::*;

  localparam int CW = (RANGE_BITS > CFG_W) ? RANGE_BITS : CFG_W;

  sweep_t          sw_r;
  sweep_t          sw_nxt;
  sector_t         sec;
  logic [CW-1:0]   r_ext;
  logic [CFG_W-1:0] r16;
  logic            in_window;
  logic            hit;
  logic [SUM_W:0]  left_add;
  logic [SUM_W:0]  right_add;
  logic            better;

  assign sec       = sector_of(angle);
  assign r_ext     = CW'(range_mm);
  // a reading inside the window is below the ceiling, so 16 bits carry it
  assign r16       = r_ext[CFG_W-1:0];
  assign in_window = (r_ext > CW'(cfg.range_floor)) && (r_ext < CW'(cfg.range_ceiling));
  assign hit       = sec.front && (r_ext > CW'(cfg.range_floor)) &&
                     (r_ext < CW'(cfg.collision_threshold)) && (r_ext >= CW'(MIN_FRONT_MM));
  assign left_add  = {1'b0, sw_r.left_sum} + (SUM_W+1)'(r16);
  assign right_add = {1'b0, sw_r.right_sum} + (SUM_W+1)'(r16);
  assign better    = !sw_r.best_found || (r16 > sw_r.best_range) ||
                     ((r16 == sw_r.best_range) && (rank_of(angle) < rank_of(sw_r.best_angle)));

  always_comb begin
    upd = sw_r;
    if (hit) begin
      upd.collision = 1'b1;
    end
    if (sec.left && in_window) begin
      upd.left_sum = (left_add > (SUM_W+1)'(SUM_MAX)) ? SUM_MAX : left_add[SUM_W-1:0];
    end
    if (sec.right && in_window) begin
      upd.right_sum = (right_add > (SUM_W+1)'(SUM_MAX)) ? SUM_MAX : right_add[SUM_W-1:0];
    end
    if (sec.search && in_window && better) begin
      upd.best_range = r16;
      upd.best_angle = angle;
      upd.best_found = 1'b1;
    end
  end

  always_comb begin
    sw_nxt = sw_r;
    if (step) begin
      sw_nxt = sweep_end ? '0 : upd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sw_r <= '0;
    end else begin
      sw_r <= sw_nxt;
    end
  end

  assign cur = sw_r;

endmodule
